// ===== hw/rtl/bvl_pkg.sv =====
// ----------------------------------------------------------------------------
// bvl_pkg
// Shared types, breakpoint tables and level quantizer for the battery
// voltage to level block.
// ----------------------------------------------------------------------------
package bvl_pkg;

    localparam int TABLE_SLOTS = 32;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int MV_W        = 13;
    localparam int PCT_W       = 7;
    localparam int DV_W        = 8;
    localparam int NUM_W       = 11;
    localparam int Q_W         = 4;
    localparam int PROD_W      = DV_W + PCT_W;

    typedef logic [MV_W-1:0]   mv_t;
    typedef logic [PCT_W-1:0]  pct_t;
    typedef logic [SLOT_W-1:0] slot_t;

    localparam pct_t PCT_EMPTY = 7'd0;
    localparam pct_t PCT_FULL  = 7'd100;

    typedef enum logic [1:0] {
        CLS_EMPTY,
        CLS_INTERP,
        CLS_FULL
    } cls_t;

    typedef struct packed {
        cls_t             cls;
        pct_t             base;
        logic [DV_W-1:0]  dv;
        logic [NUM_W-1:0] rem;
        logic [Q_W-1:0]   quo;
    } div_t;

    localparam mv_t VOLT_41 [TABLE_SLOTS] = '{
        0: 13'd3400, 1: 13'd3562, 2: 13'd3616, 3: 13'd3651, 4: 13'd3678,
        5: 13'd3711, 6: 13'd3756, 7: 13'd3818, 8: 13'd3887, 9: 13'd3973,
        10: 13'd4100, default: 13'd0
    };

    localparam mv_t VOLT_435 [TABLE_SLOTS] = '{
        0: 13'd3400, 1: 13'd3577, 2: 13'd3644, 3: 13'd3682, 4: 13'd3717,
        5: 13'd3765, 6: 13'd3832, 7: 13'd3921, 8: 13'd4027, 9: 13'd4137,
        10: 13'd4300, default: 13'd0
    };

    localparam pct_t PCT_TBL [TABLE_SLOTS] = '{
        0: 7'd0, 1: 7'd10, 2: 7'd20, 3: 7'd30, 4: 7'd40, 5: 7'd50,
        6: 7'd60, 7: 7'd70, 8: 7'd80, 9: 7'd90, 10: 7'd100, default: 7'd0
    };

    function automatic mv_t volt_at(input logic profile, input slot_t idx);
        return profile ? VOLT_435[idx] : VOLT_41[idx];
    endfunction

    function automatic pct_t pct_at(input slot_t idx);
        return PCT_TBL[idx];
    endfunction

    function automatic pct_t quantize(input pct_t raw);
        pct_t lvl;
        if (raw == 7'd0)       lvl = 7'd0;
        else if (raw <= 7'd10) lvl = 7'd5;
        else if (raw <= 7'd15) lvl = 7'd10;
        else if (raw <= 7'd20) lvl = 7'd15;
        else if (raw <= 7'd29) lvl = 7'd20;
        else if (raw <= 7'd38) lvl = 7'd30;
        else if (raw <= 7'd47) lvl = 7'd40;
        else if (raw <= 7'd56) lvl = 7'd50;
        else if (raw <= 7'd65) lvl = 7'd60;
        else if (raw <= 7'd74) lvl = 7'd70;
        else if (raw <= 7'd85) lvl = 7'd80;
        else if (raw <= 7'd96) lvl = 7'd90;
        else if (raw <= 7'd99) lvl = 7'd99;
        else                   lvl = 7'd100;
        return lvl;
    endfunction

endpackage

// ===== hw/rtl/battery_voltage_to_level_top.sv =====
// ----------------------------------------------------------------------------
// battery_voltage_to_level_top
// Battery voltage (mV) to state-of-charge percent and display level.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one beat carries one voltage sample in mV
//   (s_tdata[12:0]). Output stream m_*: one beat per sample carrying the
//   interpolated percent and the quantized display level.
//   cfg_wr_en/cfg_wr_data select the cell profile (0: 4.1 V, 1: 4.35 V);
//   write it only while no sample is in flight.
//   Throughput: one beat per cycle while m_tready is high, through a
//   7-stage pipeline: breakpoint search, segment setup, four one-bit
//   divide stages, level quantizer.
//   Reset clears all stage valid bits and selects the 4.1 V profile.
//   When m_tready is low, the output beat holds and upstream stages keep
//   filling empty slots; s_tready drops only once every stage is full.
// ----------------------------------------------------------------------------
module battery_voltage_to_level_top #(
    parameter int NUM_POINTS = 11
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [12:0] battery_millivolts, [15:13] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [6:0] raw_percent, [13:7] display_level
);
    import bvl_pkg::*;

    localparam int IDX_W   = $clog2(NUM_POINTS + 1);
    localparam int DSTAGES = Q_W;

    logic             profile_reg;

    logic             s0_valid_reg;
    logic [IDX_W-1:0] s0_idx_reg;
    mv_t              s0_mv_reg;
    logic [IDX_W-1:0] s0_idx_next;

    logic             s1_valid_reg;
    div_t             s1_reg;
    div_t             s1_next;

    logic             dvalid_reg [DSTAGES];
    div_t             dstage_reg [DSTAGES];
    div_t             dstage_next [DSTAGES];
    logic             en_d [DSTAGES];

    logic             m_tvalid_reg;
    logic [15:0]      m_tdata_reg;
    logic [15:0]      m_tdata_next;

    logic             en_out;
    logic             en1;
    logic             en0;

    slot_t            lo_slot;
    slot_t            hi_slot;
    mv_t              v_lo;
    mv_t              v_hi;
    pct_t             p_lo;
    pct_t             dp;
    logic [DV_W-1:0]  dmv;
    logic [PROD_W-1:0] prod;
    pct_t             raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            profile_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            profile_reg <= cfg_wr_data;
        end
    end

    // stall chain: a stage advances when it is empty or its successor advances
    always_comb begin
        en_out = !m_tvalid_reg || m_tready;
        en_d[DSTAGES-1] = !dvalid_reg[DSTAGES-1] || en_out;
        for (int k = DSTAGES - 2; k >= 0; k--) begin
            en_d[k] = !dvalid_reg[k] || en_d[k+1];
        end
        en1 = !s1_valid_reg || en_d[0];
        en0 = !s0_valid_reg || en1;
    end

    assign s_tready = en0;

    // find the first breakpoint at or above the sample
    always_comb begin
        s0_idx_next = IDX_W'(NUM_POINTS);
        for (int k = NUM_POINTS - 1; k >= 0; k--) begin
            if (s_tdata[MV_W-1:0] <= volt_at(profile_reg, SLOT_W'(k))) begin
                s0_idx_next = IDX_W'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (en0) begin
            s0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en0) begin
            s0_idx_reg <= s0_idx_next;
            s0_mv_reg  <= s_tdata[MV_W-1:0];
        end
    end

    // segment setup
    always_comb begin
        hi_slot = SLOT_W'(s0_idx_reg);
        lo_slot = SLOT_W'(s0_idx_reg - IDX_W'(1));
        v_lo    = volt_at(profile_reg, lo_slot);
        v_hi    = volt_at(profile_reg, hi_slot);
        p_lo    = pct_at(lo_slot);
        dp      = pct_at(hi_slot) - p_lo;
        dmv     = DV_W'(s0_mv_reg - v_lo);
        prod    = {{PCT_W{1'b0}}, dmv} * {{DV_W{1'b0}}, dp};

        s1_next.base = p_lo;
        s1_next.dv   = DV_W'(v_hi - v_lo);
        s1_next.rem  = prod[NUM_W-1:0];
        s1_next.quo  = '0;
        if (s0_idx_reg == '0) begin
            s1_next.cls = CLS_EMPTY;
        end else if (s0_idx_reg >= IDX_W'(NUM_POINTS)) begin
            s1_next.cls = CLS_FULL;
        end else begin
            s1_next.cls = CLS_INTERP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en1) begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_reg <= s1_next;
        end
    end

    // restoring divide, one quotient bit per stage, MSB first
    for (genvar g = 0; g < DSTAGES; g++) begin : g_div
        localparam int BIT = DSTAGES - 1 - g;

        div_t              din;
        logic              din_valid;
        logic [NUM_W:0]    trial;
        logic [NUM_W:0]    rem_ext;

        if (g == 0) begin : g_first
            assign din       = s1_reg;
            assign din_valid = s1_valid_reg;
        end else begin : g_rest
            assign din       = dstage_reg[g-1];
            assign din_valid = dvalid_reg[g-1];
        end

        always_comb begin
            trial   = {{(NUM_W + 1 - DV_W){1'b0}}, din.dv} << BIT;
            rem_ext = {1'b0, din.rem};
            dstage_next[g] = din;
            if (rem_ext >= trial) begin
                dstage_next[g].rem      = NUM_W'(rem_ext - trial);
                dstage_next[g].quo[BIT] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dvalid_reg[g] <= 1'b0;
            end else if (en_d[g]) begin
                dvalid_reg[g] <= din_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en_d[g]) begin
                dstage_reg[g] <= dstage_next[g];
            end
        end
    end

    // final percent and display level
    always_comb begin
        case (dstage_reg[DSTAGES-1].cls)
            CLS_EMPTY:  raw = PCT_EMPTY;
            CLS_FULL:   raw = PCT_FULL;
            CLS_INTERP: raw = dstage_reg[DSTAGES-1].base
                              + PCT_W'(dstage_reg[DSTAGES-1].quo);
            default:    raw = PCT_EMPTY;
        endcase
        if (raw > PCT_FULL) begin
            raw = PCT_FULL;
        end
        m_tdata_next = {2'b00, quantize(raw), raw};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en_out) begin
            m_tvalid_reg <= dvalid_reg[DSTAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hw/rtl/bvl_checker.sv =====
// ----------------------------------------------------------------------------
// bvl_checker
// Port-level checks for the battery voltage to level block.
// ----------------------------------------------------------------------------
module bvl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    import bvl_pkg::*;

    // hold a stalled output beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    a_raw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[6:0] <= PCT_FULL)
        else $error("raw percent above 100");

    a_level_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[13:7] == quantize(m_tdata[6:0]))
        else $error("display level does not match raw percent");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output beat valid right after reset");

endmodule

bind battery_voltage_to_level_top bvl_checker u_bvl_checker (.*);

// ===== test/tb_battery_voltage_to_level_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_battery_voltage_to_level_top
// Streams millivolt samples through the voltage-to-level block under both
// cell profiles. Each accepted beat is run through a local interpolation
// and level model, and every output beat is checked in order against it.
// Both stream sides stall at random. A long stretch runs with no stalls.
// ----------------------------------------------------------------------------
module tb_battery_voltage_to_level_top;

    import bvl_pkg::mv_t;
    import bvl_pkg::pct_t;

    localparam int          NPTS        = 11;
    localparam int          NBANDS      = 14;
    localparam int unsigned STALL_LIMIT = 5000;

    localparam int unsigned CELL41_MV [NPTS] = '{
        3400, 3562, 3616, 3651, 3678, 3711, 3756, 3818, 3887, 3973, 4100
    };
    localparam int unsigned CELL435_MV [NPTS] = '{
        3400, 3577, 3644, 3682, 3717, 3765, 3832, 3921, 4027, 4137, 4300
    };
    localparam int unsigned SOC_PCT [NPTS] = '{
        0, 10, 20, 30, 40, 50, 60, 70, 80, 90, 100
    };
    localparam int unsigned BAND_TOP [NBANDS] = '{
        0, 10, 15, 20, 29, 38, 47, 56, 65, 74, 85, 96, 99, 100
    };
    localparam int unsigned BAND_LEVEL [NBANDS] = '{
        0, 5, 10, 15, 20, 30, 40, 50, 60, 70, 80, 90, 99, 100
    };

    typedef struct packed {
        pct_t raw_pct;
        pct_t level;
    } charge_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [12:0] battery_millivolts, [15:13] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [6:0] raw_percent, [13:7] display_level

    charge_t     expected_levels[$];
    logic        cell_profile;
    bit          src_gaps;
    bit          sink_gaps;
    int unsigned fails;
    int unsigned stall_cycles;

    battery_voltage_to_level_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #10 aclk = ~aclk;

    function automatic int unsigned cell_mv(input logic prof, input int unsigned idx);
        return prof ? CELL435_MV[idx] : CELL41_MV[idx];
    endfunction

    function automatic charge_t predict_charge(input logic prof, input mv_t mv);
        int unsigned seg;
        int unsigned raw;
        int unsigned band;
        charge_t     res;
        seg = 0;
        while (seg < NPTS && int'(mv) > cell_mv(prof, seg))
            seg++;
        if (seg == 0)
            raw = 0;
        else if (seg >= NPTS)
            raw = 100;
        else
            raw = SOC_PCT[seg-1] + (int'(mv) - cell_mv(prof, seg-1))
                  * (SOC_PCT[seg] - SOC_PCT[seg-1])
                  / (cell_mv(prof, seg) - cell_mv(prof, seg-1));
        if (raw > 100)
            raw = 100;
        band = 0;
        while (band < NBANDS-1 && raw > BAND_TOP[band])
            band++;
        res.raw_pct = pct_t'(raw);
        res.level   = pct_t'(BAND_LEVEL[band]);
        return res;
    endfunction

    function automatic mv_t pick_mv(input logic prof);
        int unsigned roll;
        int unsigned v;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            v = $urandom_range(3380, 4320);
        else if (roll < 85)
            v = cell_mv(prof, $urandom_range(0, NPTS-1)) + $urandom_range(0, 4) - 2;
        else
            v = $urandom_range(0, 8191);
        return mv_t'(v);
    endfunction

    // Hold the beat until accepted; the model sees it at acceptance.
    task automatic send_sample(input mv_t mv);
        while (src_gaps && $urandom_range(0, 99) < 9) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, mv};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        expected_levels.push_back(predict_charge(cell_profile, mv));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_levels.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_cell_profile(input logic prof);
        wait_drained();
        repeat (8) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= prof;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        cell_profile = prof;
    endtask

    task automatic test_edges_cell41();
        int unsigned pts [11] = '{0, 3399, 3400, 3401, 3562, 3563, 3972, 4099,
                                  4100, 4101, 8191};
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
        foreach (pts[k])
            send_sample(mv_t'(pts[k]));
        wait_drained();
    endtask

    task automatic test_edges_cell435();
        int unsigned pts [11] = '{0, 3400, 3401, 3577, 3578, 4137, 4299, 4300,
                                  4301, 4096, 8191};
        set_cell_profile(1'b1);
        foreach (pts[k])
            send_sample(mv_t'(pts[k]));
        wait_drained();
    endtask

    task automatic test_random(input logic prof, input int unsigned count, input bit gaps);
        set_cell_profile(prof);
        src_gaps  = gaps;
        sink_gaps = gaps;
        repeat (count)
            send_sample(pick_mv(prof));
        wait_drained();
    endtask

    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= !sink_gaps || ($urandom_range(0, 99) >= 9);
    end

    always @(posedge aclk) begin
        charge_t exp_c;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_levels.size() == 0) begin
                $display("%0t: unexpected beat, raw %0d level %0d", $time,
                         m_tdata[6:0], m_tdata[13:7]);
                fails++;
            end else begin
                exp_c = expected_levels.pop_front();
                if (m_tdata[6:0] !== exp_c.raw_pct) begin
                    $display("%0t: raw_percent expected %0d actual %0d", $time,
                             exp_c.raw_pct, m_tdata[6:0]);
                    fails++;
                end
                if (m_tdata[13:7] !== exp_c.level) begin
                    $display("%0t: display_level expected %0d actual %0d", $time,
                             exp_c.level, m_tdata[13:7]);
                    fails++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cell_profile = 1'b0;
        src_gaps     = 1'b1;
        sink_gaps    = 1'b1;
        fails        = 0;
        stall_cycles = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_edges_cell41();
        test_edges_cell435();
        test_random(1'b0, 200, 1'b1);
        test_random(1'b1, 200, 1'b1);
        test_random(1'b0, 150, 1'b0);
        test_random(1'b1, 100, 1'b1);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (fails == 0 && expected_levels.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
